// ===== src/aop_pkg.sv =====
// ----------------------------------------------------------------------------
// aop_pkg: shared types and codes for the age-ordered slot pool allocator
// Holds the operation and status codes, the sequencer state type and the
// result record passed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package aop_pkg;

	// Default pool size and the fixed width of slot fields on the ports.
	localparam int AOP_POOL_SLOTS = 1024;
	localparam int AOP_SLOT_W     = 10;

	// Operation codes.
	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_ALLOC   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_RECYCLED = 3'd2,
		ST_REFUSED  = 3'd3,
		ST_INACTIVE = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_FETCH,
		S_DECIDE,
		S_FIXA_RD,
		S_FIXA_WR,
		S_FIXB_RD,
		S_FIXB_WR,
		S_DONE
	} seq_state_t;

	// One result item.
	typedef struct packed {
		logic [AOP_SLOT_W-1:0] granted_slot;
		status_t               status;
	} res_t;

endpackage

// ===== src/aop_ram.sv =====
// ----------------------------------------------------------------------------
// aop_ram: slot link memory
// One write port and one read port; read data is registered, so it shows
// the entry addressed in the previous cycle.
// ----------------------------------------------------------------------------
module aop_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 23
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Synchronous write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Synchronous read, registered output.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/aop_seq.sv =====
// ----------------------------------------------------------------------------
// aop_seq: pool sequencer
// Keeps the list heads in registers and walks the link memory for each
// item: one read of the target slot, a write of it when it changes, and up to
// two read-modify-write fixes of neighbor links. Clear sweeps every entry.
// ----------------------------------------------------------------------------
module aop_seq
	import aop_pkg::*;
#(
	parameter int POOL_SLOTS = AOP_POOL_SLOTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [1:0]                           req_op,
	input  logic                                 req_replace,
	input  logic [AOP_SLOT_W-1:0]                req_index,
	input  logic                                 req_allowed,
	input  logic                                 res_room,
	output logic                                 idle,
	output logic                                 res_valid,
	output res_t                                 res,
	output logic                                 mem_we,
	output logic [$clog2(POOL_SLOTS)-1:0]        mem_waddr,
	output logic [2*$clog2(POOL_SLOTS+1):0]      mem_wdata,
	output logic [$clog2(POOL_SLOTS)-1:0]        mem_raddr,
	input  logic [2*$clog2(POOL_SLOTS+1):0]      mem_rdata
);

	localparam int LW = $clog2(POOL_SLOTS + 1);
	localparam int AW = $clog2(POOL_SLOTS);
	localparam int DW = 2 * LW + 1;
	localparam logic [LW-1:0] NONE = LW'(POOL_SLOTS);
	localparam logic [AW-1:0] LAST = AW'(POOL_SLOTS - 1);

	function automatic logic is_slot(input logic [LW-1:0] v);
		return v < NONE;
	endfunction

	function automatic logic [LW-1:0] norm(input logic [LW-1:0] v);
		return is_slot(v) ? v : NONE;
	endfunction

	seq_state_t state_q, state_d;
	logic [LW-1:0] young_q, young_d;
	logic [LW-1:0] old_q, old_d;
	logic [LW-1:0] free_q, free_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic          report_q, report_d;

	logic [1:0]    op_q;
	logic          rep_q;
	logic          allowed_q;
	logic [LW-1:0] tgt_q, tgt_d;
	logic [LW-1:0] grant_q, grant_d;
	status_t       status_q, status_d;
	logic          fixa_en_q, fixa_en_d;
	logic [AW-1:0] fixa_addr_q, fixa_addr_d;
	logic [LW-1:0] fixa_val_q, fixa_val_d;
	logic          fixb_en_q, fixb_en_d;
	logic [AW-1:0] fixb_addr_q, fixb_addr_d;
	logic [LW-1:0] fixb_val_q, fixb_val_d;

	// Fields of the entry read in the previous cycle.
	logic          d_act;
	logic [LW-1:0] d_old;
	logic [LW-1:0] d_new;
	logic          idx_ok;

	assign d_act  = mem_rdata[DW-1];
	assign d_old  = mem_rdata[DW-2:LW];
	assign d_new  = mem_rdata[LW-1:0];
	assign idx_ok = 32'(req_index) < POOL_SLOTS;

	assign idle          = state_q == S_IDLE;
	assign res.granted_slot = AOP_SLOT_W'(grant_q);
	assign res.status    = status_q;

	// Control state and list heads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			young_q  <= NONE;
			old_q    <= NONE;
			free_q   <= '0;
			cnt_q    <= '0;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			young_q  <= young_d;
			old_q    <= old_d;
			free_q   <= free_d;
			cnt_q    <= cnt_d;
			report_q <= report_d;
		end
	end

	// Item fields and per-item work registers.
	always_ff @(posedge clk) begin
		if (start) begin
			op_q      <= req_op;
			rep_q     <= req_replace;
			allowed_q <= req_allowed;
		end
		tgt_q       <= tgt_d;
		grant_q     <= grant_d;
		status_q    <= status_d;
		fixa_en_q   <= fixa_en_d;
		fixa_addr_q <= fixa_addr_d;
		fixa_val_q  <= fixa_val_d;
		fixb_en_q   <= fixb_en_d;
		fixb_addr_q <= fixb_addr_d;
		fixb_val_q  <= fixb_val_d;
	end

	// Next state, memory accesses and list updates.
	always_comb begin
		state_d     = state_q;
		young_d     = young_q;
		old_d       = old_q;
		free_d      = free_q;
		cnt_d       = cnt_q;
		report_d    = report_q;
		tgt_d       = tgt_q;
		grant_d     = grant_q;
		status_d    = status_q;
		fixa_en_d   = fixa_en_q;
		fixa_addr_d = fixa_addr_q;
		fixa_val_d  = fixa_val_q;
		fixb_en_d   = fixb_en_q;
		fixb_addr_d = fixb_addr_q;
		fixb_val_d  = fixb_val_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_raddr   = '0;
		res_valid   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					grant_d   = '0;
					status_d  = ST_OK;
					fixa_en_d = 1'b0;
					fixb_en_d = 1'b0;
					unique case (req_op)
						OP_CLEAR: begin
							young_d  = NONE;
							old_d    = NONE;
							free_d   = '0;
							cnt_d    = '0;
							report_d = 1'b1;
							state_d  = S_CLEAR;
						end
						OP_ALLOC: begin
							tgt_d   = is_slot(free_q) ? free_q : old_q;
							state_d = S_FETCH;
						end
						OP_RELEASE: begin
							tgt_d   = idx_ok ? LW'(req_index) : NONE;
							state_d = S_FETCH;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			// Rebuild the free chain one entry per cycle.
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = {1'b0,
					(cnt_q == '0) ? NONE : LW'(cnt_q) - LW'(1),
					LW'(cnt_q) + LW'(1)};
				cnt_d = cnt_q + AW'(1);
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = report_q ? S_DONE : S_IDLE;
				end
			end

			S_FETCH: begin
				mem_raddr = is_slot(tgt_q) ? tgt_q[AW-1:0] : '0;
				state_d   = S_DECIDE;
			end

			// Target entry is on the read port: choose the case and queue fixes.
			S_DECIDE: begin
				if (op_q == OP_ALLOC) begin
					if (is_slot(free_q)) begin
						free_d    = norm(d_new);
						mem_we    = 1'b1;
						mem_waddr = free_q[AW-1:0];
						mem_wdata = {1'b1, NONE, norm(young_q)};
						young_d   = free_q;
						grant_d   = free_q;
						if (is_slot(young_q)) begin
							fixb_en_d   = 1'b1;
							fixb_addr_d = young_q[AW-1:0];
							fixb_val_d  = free_q;
						end else begin
							old_d = free_q;
						end
					end else if (rep_q && is_slot(old_q)) begin
						grant_d  = old_q;
						status_d = ST_RECYCLED;
						// Only a slot with a younger neighbor moves.
						if (is_slot(d_old)) begin
							fixa_en_d   = 1'b1;
							fixa_addr_d = d_old[AW-1:0];
							fixa_val_d  = norm(d_new);
							old_d       = d_old;
							mem_we      = 1'b1;
							mem_waddr   = old_q[AW-1:0];
							mem_wdata   = {1'b1, NONE, norm(young_q)};
							young_d     = old_q;
							fixb_en_d   = 1'b1;
							fixb_addr_d = young_q[AW-1:0];
							fixb_val_d  = old_q;
						end
					end else begin
						status_d = ST_FULL;
					end
				end else begin
					if (!is_slot(tgt_q) || !d_act) begin
						status_d = ST_INACTIVE;
					end else if (!allowed_q) begin
						status_d = ST_REFUSED;
					end else begin
						if (is_slot(d_old)) begin
							fixa_en_d   = 1'b1;
							fixa_addr_d = d_old[AW-1:0];
							fixa_val_d  = norm(d_new);
						end else begin
							young_d = norm(d_new);
						end
						if (is_slot(d_new)) begin
							fixb_en_d   = 1'b1;
							fixb_addr_d = d_new[AW-1:0];
							fixb_val_d  = norm(d_old);
						end else begin
							old_d = norm(d_old);
						end
						mem_we    = 1'b1;
						mem_waddr = tgt_q[AW-1:0];
						mem_wdata = {1'b0, NONE, norm(free_q)};
						free_d    = tgt_q;
					end
				end
				if (fixa_en_d) begin
					state_d = S_FIXA_RD;
				end else if (fixb_en_d) begin
					state_d = S_FIXB_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			// Rewrite the newer link of a neighbor.
			S_FIXA_RD: begin
				mem_raddr = fixa_addr_q;
				state_d   = S_FIXA_WR;
			end
			S_FIXA_WR: begin
				mem_we    = 1'b1;
				mem_waddr = fixa_addr_q;
				mem_wdata = {mem_rdata[DW-1:LW], fixa_val_q};
				state_d   = fixb_en_q ? S_FIXB_RD : S_DONE;
			end

			// Rewrite the older link of a neighbor.
			S_FIXB_RD: begin
				mem_raddr = fixb_addr_q;
				state_d   = S_FIXB_WR;
			end
			S_FIXB_WR: begin
				mem_we    = 1'b1;
				mem_waddr = fixb_addr_q;
				mem_wdata = {mem_rdata[DW-1], fixb_val_q, mem_rdata[LW-1:0]};
				state_d   = S_DONE;
			end

			// Hand the result to the output register when it has room.
			S_DONE: begin
				if (res_room) begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// An item is only started while the sequencer is idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("item started while the sequencer is busy");

	// A result is only released when the output register can take it.
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_room)
		else $error("result released with no room in the output register");

	// The active list is either empty at both ends or at neither.
	a_heads_agree: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ((young_q == NONE) == (old_q == NONE)))
		else $error("youngest and oldest pointers disagree on an empty list");

	// The free head is always a slot or the none mark.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NONE)
		else $error("free head out of range");

	// No grant goes with a full-pool refusal.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_FULL |-> res.granted_slot == '0)
		else $error("slot granted on a full pool without recycling");

endmodule

// ===== src/age_ordered_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// age_ordered_slot_pool_allocator: slot pool with age-ordered recycling
// Free chain and youngest-to-oldest active list kept in one link memory;
// a sequencer walks the links and an output register holds each result.
//
//   channel  signals                                              direction
//   in       in_valid, in_ready, operation, replace_when_full,   into block
//            slot_index, release_allowed
//   out      out_valid, out_ready, granted_slot, status           out of block
//
// An allocate or release steps through a read of the target slot, a
// decision step that may write it, up to two read-modify-write fixes of
// neighbor links (a read state and a write state each), a step to hand off
// the result and the idle state in which the next item is taken. An unused
// operation code goes straight from idle to the hand-off step.
// Clear sweeps the memory one entry a cycle, then reports through the hand-off step.
// After reset the same sweep runs with in_ready low.
// A result waiting on out_ready holds the sequencer in its final step; the
// next item is taken as soon as that result moves to the output register.
// ----------------------------------------------------------------------------
module age_ordered_slot_pool_allocator
	import aop_pkg::*;
#(
	parameter int POOL_SLOTS = AOP_POOL_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic                  replace_when_full,
	input  logic [AOP_SLOT_W-1:0] slot_index,
	input  logic                  release_allowed,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [AOP_SLOT_W-1:0] granted_slot,
	output logic [2:0]            status
);

	localparam int LW = $clog2(POOL_SLOTS + 1);
	localparam int AW = $clog2(POOL_SLOTS);
	localparam int DW = 2 * LW + 1;

	logic          start;
	logic          seq_idle;
	logic          res_room;
	logic          res_valid;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;

	logic out_valid_q;
	res_t out_res_q;

	// Input handshake.
	assign in_ready = seq_idle;
	assign start    = in_valid && seq_idle;
	assign res_room = !out_valid_q || out_ready;

	aop_seq #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_op     (operation),
		.req_replace(replace_when_full),
		.req_index  (slot_index),
		.req_allowed(release_allowed),
		.res_room   (res_room),
		.idle       (seq_idle),
		.res_valid  (res_valid),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	aop_ram #(
		.DEPTH(POOL_SLOTS),
		.DW   (DW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = out_res_q.granted_slot;
	assign status       = out_res_q.status;

endmodule
